@@ hw/rtl/scaled_font_text_rasterizer_defines.svh @@
// Assertion macros shared by the rasterizer RTL.
// No dependencies.
`ifndef SCALED_FONT_TEXT_RASTERIZER_DEFINES_SVH
`define SCALED_FONT_TEXT_RASTERIZER_DEFINES_SVH
// implication checked on every clock, off during reset
`define SFT_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("label failed");
// implication with the consequent checked on the following clock
`define SFT_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("label failed");
`endif

@@ hw/rtl/sftr_pkg.sv @@
// Package for the scaled font text rasterizer: op codes, colors, font ROM.
// No dependencies.
package sftr_pkg;
    typedef enum logic [1:0] {OP_SET = 2'd0, OP_CHAR = 2'd1, OP_CLEAR = 2'd2, OP_READ = 2'd3}
        op_t;
    localparam logic [1:0] COL_BLACK  = 2'd0;
    localparam logic [1:0] COL_WHITE  = 2'd1;
    localparam logic [1:0] COL_INVERT = 2'd2;
    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;
    localparam logic [7:0] CHAR_SUBST = 8'h3F;
    localparam int FONT_COLS = 5;

    typedef logic [7:0] glyph_col_t;

    function automatic logic [39:0] font_row(input logic [6:0] idx);
        logic [39:0] v;
        v = '0;
        case (idx)
            7'd0:  v = 40'h0000000000; 7'd1:  v = 40'h00005F0000; 7'd2:  v = 40'h0007000700;
            7'd3:  v = 40'h147F147F14; 7'd4:  v = 40'h242A7F2A12; 7'd5:  v = 40'h2313086462;
            7'd6:  v = 40'h3649552250; 7'd7:  v = 40'h0005030000; 7'd8:  v = 40'h001C224100;
            7'd9:  v = 40'h0041221C00; 7'd10: v = 40'h14083E0814; 7'd11: v = 40'h08083E0808;
            7'd12: v = 40'h0050300000; 7'd13: v = 40'h0808080808; 7'd14: v = 40'h0060600000;
            7'd15: v = 40'h2010080402; 7'd16: v = 40'h3E5149453E; 7'd17: v = 40'h00427F4000;
            7'd18: v = 40'h4261514946; 7'd19: v = 40'h2141454B31; 7'd20: v = 40'h1814127F10;
            7'd21: v = 40'h2745454539; 7'd22: v = 40'h3C4A494930; 7'd23: v = 40'h0171090503;
            7'd24: v = 40'h3649494936; 7'd25: v = 40'h064949291E; 7'd26: v = 40'h0036360000;
            7'd27: v = 40'h0056360000; 7'd28: v = 40'h0814224100; 7'd29: v = 40'h1414141414;
            7'd30: v = 40'h0041221408; 7'd31: v = 40'h0201510906; 7'd32: v = 40'h324979413E;
            7'd33: v = 40'h7E1111117E; 7'd34: v = 40'h7F49494936; 7'd35: v = 40'h3E41414122;
            7'd36: v = 40'h7F4141221C; 7'd37: v = 40'h7F49494941; 7'd38: v = 40'h7F09090901;
            7'd39: v = 40'h3E4149497A; 7'd40: v = 40'h7F0808087F; 7'd41: v = 40'h00417F4100;
            7'd42: v = 40'h2040413F01; 7'd43: v = 40'h7F08142241; 7'd44: v = 40'h7F40404040;
            7'd45: v = 40'h7F020C027F; 7'd46: v = 40'h7F0408107F; 7'd47: v = 40'h3E4141413E;
            7'd48: v = 40'h7F09090906; 7'd49: v = 40'h3E4151215E; 7'd50: v = 40'h7F09192946;
            7'd51: v = 40'h4649494931; 7'd52: v = 40'h01017F0101; 7'd53: v = 40'h3F4040403F;
            7'd54: v = 40'h1F2040201F; 7'd55: v = 40'h3F4038403F; 7'd56: v = 40'h6314081463;
            7'd57: v = 40'h0708700807; 7'd58: v = 40'h6151494543; 7'd59: v = 40'h007F414100;
            7'd60: v = 40'h0204081020; 7'd61: v = 40'h0041417F00; 7'd62: v = 40'h0402010204;
            7'd63: v = 40'h4040404040; 7'd64: v = 40'h0001020400; 7'd65: v = 40'h2054545478;
            7'd66: v = 40'h7F48444438; 7'd67: v = 40'h3844444420; 7'd68: v = 40'h384444487F;
            7'd69: v = 40'h3854545418; 7'd70: v = 40'h087E090102; 7'd71: v = 40'h0C5252523E;
            7'd72: v = 40'h7F08040478; 7'd73: v = 40'h00447D4000; 7'd74: v = 40'h2040443D00;
            7'd75: v = 40'h7F10284400; 7'd76: v = 40'h00417F4000; 7'd77: v = 40'h7C04180478;
            7'd78: v = 40'h7C08040478; 7'd79: v = 40'h3844444438; 7'd80: v = 40'h7C14141408;
            7'd81: v = 40'h081414187C; 7'd82: v = 40'h7C08040408; 7'd83: v = 40'h4854545420;
            7'd84: v = 40'h043F444020; 7'd85: v = 40'h3C4040207C; 7'd86: v = 40'h1C2040201C;
            7'd87: v = 40'h3C4030403C; 7'd88: v = 40'h4428102844; 7'd89: v = 40'h0C5050503C;
            7'd90: v = 40'h4464544C44; 7'd91: v = 40'h0008364100; 7'd92: v = 40'h00007F0000;
            7'd93: v = 40'h0041360800; 7'd94: v = 40'h0804081008;
            default: v = '0;
        endcase
        return v;
    endfunction

    // column c of glyph; column 0 is the top byte of the packed row
    function automatic glyph_col_t font_col(input logic [6:0] idx, input logic [2:0] c);
        logic [39:0] r;
        r = font_row(idx);
        case (c)
            3'd0: return r[39:32];
            3'd1: return r[31:24];
            3'd2: return r[23:16];
            3'd3: return r[15:8];
            3'd4: return r[7:0];
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] apply_color(input logic [7:0] b, input logic [7:0] m,
                                               input logic [1:0] col);
        case (col)
            COL_BLACK:  return b & ~m;
            COL_WHITE:  return b | m;
            COL_INVERT: return b ^ m;
            default:    return b;
        endcase
    endfunction
endpackage

@@ hw/rtl/scaled_font_text_rasterizer.sv @@
// Scaled 5x7 text rasterizer over a page-organized monochrome frame store.
// Takes sftr_pkg and scaled_font_text_rasterizer_defines.svh.
//
// One item at a time: s_tready is low from acceptance until the result item has
// been taken. After reset a clearing pass over all PANEL_WIDTH*PANEL_PAGES bytes
// (1024) zeroes the store; a clear op runs the same pass, then returns a result.
// Set pixel goes through a read, a write and the result state; read goes through
// a read wait, a read output and the result state. Draw character works one cell
// column at a time: a head step, a build pass over up to 8*scale panel rows that
// marks the column's row masks, then for each of the scale block columns one
// read-modify-write per page the cell touches, then a step to the next column. The
// store port does one read-modify-write at a time.
`include "scaled_font_text_rasterizer_defines.svh"
module scaled_font_text_rasterizer #(
    parameter int PANEL_WIDTH   = 128,
    parameter int PANEL_PAGES   = 8,
    parameter int CELL_COLUMNS  = 6,
    parameter int CELL_ROWS     = 8,
    parameter int GLYPH_COLUMNS = 5,
    parameter int GLYPH_ROWS    = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // op[1:0], pen_x[8:2], pen_y[14:9], color[16:15], char_code[24:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[0], next_x[8:1], line_full[9], read_data[17:10]
);
    import sftr_pkg::*;

    localparam int DEPTH      = PANEL_WIDTH * PANEL_PAGES;
    localparam int AW         = $clog2(DEPTH);
    localparam int PANEL_ROWS = PANEL_PAGES * 8;
    localparam int MAX_SCALE  = PANEL_ROWS / CELL_ROWS;
    localparam int RW         = $clog2(PANEL_ROWS);
    localparam int PGW        = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;

    localparam logic [1:0] REG_SCALE = 2'd0;
    localparam logic [1:0] REG_BG    = 2'd1;
    localparam logic [1:0] REG_SWAP  = 2'd2;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_WR, S_CCOL, S_CBLD, S_CPG, S_CRD, S_CWR, S_RDW, S_RDO, S_OUT
    } state_t;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    state_t      state_reg;
    logic [AW-1:0] addr_reg;
    logic [3:0]  scale_reg;
    logic [1:0]  bg_reg;
    logic        swap_reg;
    logic [1:0]  op_reg;
    logic [8:0]  x_reg;       // pen column as it advances
    logic [6:0]  y_reg;
    logic [1:0]  fg_reg, bgc_reg;
    logic [6:0]  gidx_reg;
    logic [3:0]  col_reg;
    logic [2:0]  row_reg;     // cell row
    logic [3:0]  sy_reg;
    logic [3:0]  sx_reg;
    logic [RW:0] py_reg;
    logic [PGW-1:0] page_reg;
    logic [PANEL_ROWS-1:0] cell_reg;  // panel rows covered by the cell column
    logic [PANEL_ROWS-1:0] on_reg;    // covered rows where the glyph is lit
    logic [7:0]  mask_reg;    // pixel bit for set
    logic [1:0]  pc_reg;      // pixel color for set
    logic        status_reg;
    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    logic        we;
    logic [7:0]  wdata;

    // unpacked input fields
    logic [1:0] in_op;
    logic [6:0] in_x;
    logic [5:0] in_y;
    logic [1:0] in_col;
    logic [7:0] in_code;
    assign in_op   = s_tdata[1:0];
    assign in_x    = s_tdata[8:2];
    assign in_y    = s_tdata[14:9];
    assign in_col  = s_tdata[16:15];
    assign in_code = s_tdata[24:17];

    logic accept;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    logic        col_on;
    glyph_col_t  gcol;
    assign gcol = font_col(gidx_reg, col_reg[2:0]);
    assign col_on = (32'(col_reg) < GLYPH_COLUMNS) && (32'(col_reg) < FONT_COLS) &&
                    (32'(row_reg) < GLYPH_ROWS) && gcol[row_reg];

    logic [PGW-1:0] page0;
    logic [7:0]     cell_byte, on_byte;
    logic [AW-1:0]  page_addr;
    assign page0     = PGW'(y_reg[6:3]);
    assign cell_byte = cell_reg[{page_reg, 3'b000} +: 8];
    assign on_byte   = on_reg[{page_reg, 3'b000} +: 8];
    assign page_addr = AW'(32'(x_reg) + 32'(sx_reg) + 32'(page_reg) * PANEL_WIDTH);

    logic [7:0] out_next_x;
    assign out_next_x = (x_reg > 9'd255) ? 8'hFF : x_reg[7:0];

    always_ff @(posedge aclk) begin
        if (we) mem[addr_reg] <= wdata;
        rdata_reg <= mem[addr_reg];
    end

    always_comb begin
        we = 1'b0;
        wdata = rdata_reg;
        case (state_reg)
            S_CLR: begin we = 1'b1; wdata = '0; end
            S_WR:  begin we = 1'b1; wdata = apply_color(rdata_reg, mask_reg, pc_reg); end
            S_CWR: begin
                we = 1'b1;
                wdata = apply_color(apply_color(rdata_reg, on_byte, fg_reg),
                                    cell_byte & ~on_byte, bgc_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            addr_reg    <= '0;
            scale_reg   <= 4'd1;
            bg_reg      <= COL_BLACK;
            swap_reg    <= 1'b0;
            op_reg      <= OP_SET;
            status_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_SCALE: scale_reg <= cfg_wdata;
                    REG_BG:    bg_reg <= cfg_wdata[1:0];
                    REG_SWAP:  swap_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR: begin
                    addr_reg <= addr_reg + 1'b1;
                    if (32'(addr_reg) == DEPTH - 1) begin
                        addr_reg <= '0;
                        state_reg <= (op_reg == OP_CLEAR) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: if (accept) begin
                    op_reg     <= in_op;
                    x_reg      <= {2'b0, in_x};
                    y_reg      <= {1'b0, in_y};
                    status_reg <= 1'b0;
                    fg_reg     <= swap_reg ? bg_reg : in_col;
                    bgc_reg    <= swap_reg ? in_col : bg_reg;
                    gidx_reg   <= (in_code < CHAR_FIRST || in_code > CHAR_LAST) ?
                                  7'(CHAR_SUBST - CHAR_FIRST) : 7'(in_code - CHAR_FIRST);
                    col_reg    <= '0;
                    pc_reg     <= in_col;
                    mask_reg   <= 8'(1) << in_y[2:0];
                    addr_reg   <= AW'(32'(in_x) + 32'(in_y[5:3]) * PANEL_WIDTH);
                    unique case (op_t'(in_op))
                        OP_SET: begin
                            if (32'(in_x) >= PANEL_WIDTH || 32'(in_y) >= PANEL_ROWS) begin
                                status_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end else state_reg <= S_RD;
                        end
                        OP_CHAR: begin
                            if (scale_reg == 0 || 32'(scale_reg) > MAX_SCALE ||
                                32'(in_x) >= PANEL_WIDTH || 32'(in_y) >= PANEL_ROWS) begin
                                status_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end else state_reg <= S_CCOL;
                        end
                        OP_CLEAR: begin
                            addr_reg <= '0;
                            state_reg <= S_CLR;
                        end
                        OP_READ: begin
                            if (32'(in_x) >= PANEL_WIDTH || 32'(in_y[5:3]) >= PANEL_PAGES) begin
                                status_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end else state_reg <= S_RDW;
                        end
                        default: ;
                    endcase
                end
                S_RD:  state_reg <= S_WR;
                S_WR:  state_reg <= S_OUT;
                S_RDW: state_reg <= S_RDO;
                S_RDO: state_reg <= S_OUT;
                S_CCOL: begin
                    // column loop head
                    if (32'(col_reg) >= CELL_COLUMNS || 32'(x_reg) >= PANEL_WIDTH)
                        state_reg <= S_OUT;
                    else begin
                        py_reg <= (RW+1)'(y_reg);
                        row_reg <= '0;
                        sy_reg <= '0;
                        cell_reg <= '0;
                        on_reg <= '0;
                        state_reg <= S_CBLD;
                    end
                end
                S_CBLD: begin
                    // one panel row of the scaled cell column per cycle
                    if (32'(py_reg) >= PANEL_ROWS) begin
                        sx_reg <= '0;
                        page_reg <= page0;
                        state_reg <= S_CPG;
                    end else begin
                        cell_reg[py_reg[RW-1:0]] <= 1'b1;
                        on_reg[py_reg[RW-1:0]] <= col_on;
                        py_reg <= py_reg + 1'b1;
                        if (sy_reg == scale_reg - 4'd1) begin
                            sy_reg <= '0;
                            if (32'(row_reg) == CELL_ROWS - 1) begin
                                sx_reg <= '0;
                                page_reg <= page0;
                                state_reg <= S_CPG;
                            end else row_reg <= row_reg + 1'b1;
                        end else sy_reg <= sy_reg + 1'b1;
                    end
                end
                S_CPG: begin
                    if (sx_reg >= scale_reg || 32'(x_reg) + 32'(sx_reg) >= PANEL_WIDTH) begin
                        x_reg <= x_reg + 9'(scale_reg);
                        col_reg <= col_reg + 1'b1;
                        state_reg <= S_CCOL;
                    end else if (cell_byte == 8'h00) begin
                        // below the cell: next block column
                        sx_reg <= sx_reg + 1'b1;
                        page_reg <= page0;
                    end else begin
                        addr_reg <= page_addr;
                        state_reg <= S_CRD;
                    end
                end
                S_CRD: state_reg <= S_CWR;
                S_CWR: begin
                    if (32'(page_reg) == PANEL_PAGES - 1) begin
                        sx_reg <= sx_reg + 1'b1;
                        page_reg <= page0;
                    end else page_reg <= page_reg + 1'b1;
                    state_reg <= S_CPG;
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    m_data_reg <= {6'b0,
                                   (op_reg == OP_READ && !status_reg) ? rdata_reg : 8'h00,
                                   (op_reg == OP_CHAR) && (32'(x_reg) >= PANEL_WIDTH),
                                   (op_reg == OP_CHAR) ? out_next_x : 8'h00,
                                   status_reg};
                    op_reg <= OP_SET;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SFT_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_tready, state_reg == S_IDLE)
    `SFT_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `SFT_ASSERT_IMP(a_no_write_idle, aclk, aresetn, state_reg == S_IDLE, !we)
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for scaled_font_text_rasterizer: pixel set, text draw, clear, read.
// Depends on sftr_pkg and the rasterizer RTL; carries its own frame store and font predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sftr_pkg::*;

    localparam int WIDTH = 128;
    localparam int PAGES = 8;
    localparam int ROWS = PAGES * 8;
    localparam int MAX_SCALE = ROWS / 8;

    localparam logic [1:0] REG_SCALE = 2'd0;
    localparam logic [1:0] REG_BG    = 2'd1;
    localparam logic [1:0] REG_SWAP  = 2'd2;
    localparam logic [1:0] COL_KEEP  = 2'd3;

    // glyph columns, column 0 in the top byte, codes 0x20..0x7E
    localparam logic [39:0] GLYPHS [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic [1:0] color;
        logic [5:0] pen_y;
        logic [6:0] pen_x;
        op_t        op;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       line_full;
        logic [7:0] next_x;
        logic       status;
    } resp_t;

    class raster_scoreboard;
        logic [7:0] pixels [WIDTH*PAGES];
        logic [3:0] scale;
        logic [1:0] bg_color;
        logic       swap;
        resp_t      pending [$];
        int         mismatches;
        int         results;

        function void init();
            foreach (pixels[i]) pixels[i] = 8'h00;
            scale = 4'd1;
            bg_color = COL_BLACK;
            swap = 1'b0;
            mismatches = 0;
            results = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [3:0] val);
            case (idx)
                REG_SCALE: scale = val;
                REG_BG:    bg_color = val[1:0];
                REG_SWAP:  swap = val[0];
                default: ;
            endcase
        endfunction

        function void plot(int x, int y, logic [1:0] col);
            int idx;
            logic [7:0] bit_mask;
            idx = x + (y / 8) * WIDTH;
            bit_mask = 8'h01 << (y % 8);
            case (col)
                COL_BLACK:  pixels[idx] = pixels[idx] & ~bit_mask;
                COL_WHITE:  pixels[idx] = pixels[idx] | bit_mask;
                COL_INVERT: pixels[idx] = pixels[idx] ^ bit_mask;
                default: ;
            endcase
        endfunction

        function int render_glyph(int x, int y, logic [7:0] code, logic [1:0] fg_in);
            logic [1:0] fg, bg;
            logic [39:0] glyph;
            logic [7:0] colbits;
            int s;
            bit lit;
            fg = swap ? bg_color : fg_in;
            bg = swap ? fg_in : bg_color;
            s = scale;
            if (code < CHAR_FIRST || code > CHAR_LAST) code = CHAR_SUBST;
            glyph = GLYPHS[code - CHAR_FIRST];
            for (int c = 0; c < 6 && x < WIDTH; c++) begin
                colbits = (c < 5) ? glyph[39 - 8*c -: 8] : 8'h00;
                for (int r = 0; r < 8; r++) begin
                    lit = (r < 7) && colbits[r];
                    for (int sx = 0; sx < s; sx++)
                        for (int sy = 0; sy < s; sy++)
                            if (x + sx < WIDTH && y + r*s + sy < ROWS)
                                plot(x + sx, y + r*s + sy, lit ? fg : bg);
                end
                x += s;
            end
            return x;
        endfunction

        function void note_cmd(cmd_t cmd);
            resp_t exp_r;
            int x, y, stop_x;
            exp_r = '0;
            x = cmd.pen_x;
            y = cmd.pen_y;
            case (cmd.op)
                OP_SET: begin
                    if (x >= WIDTH || y >= ROWS) exp_r.status = 1'b1;
                    else plot(x, y, cmd.color);
                end
                OP_CHAR: begin
                    if (scale == 0 || scale > MAX_SCALE || x >= WIDTH || y >= ROWS) begin
                        exp_r.status = 1'b1;
                        stop_x = x;
                    end else begin
                        stop_x = render_glyph(x, y, cmd.char_code, cmd.color);
                    end
                    exp_r.line_full = stop_x >= WIDTH;
                    exp_r.next_x = stop_x > 255 ? 8'hFF : 8'(stop_x);
                end
                OP_CLEAR: foreach (pixels[i]) pixels[i] = 8'h00;
                default: begin
                    if (x >= WIDTH || y / 8 >= PAGES) exp_r.status = 1'b1;
                    else exp_r.read_data = pixels[x + (y / 8) * WIDTH];
                end
            endcase
            pending.push_back(exp_r);
        endfunction

        function void check_result(resp_t got);
            resp_t exp_r;
            results++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status || got.next_x !== exp_r.next_x ||
                got.line_full !== exp_r.line_full || got.read_data !== exp_r.read_data) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: status %b/%b next_x %0d/%0d full %b/%b data %h/%h",
                             results, exp_r.status, got.status, exp_r.next_x, got.next_x,
                             exp_r.line_full, got.line_full, exp_r.read_data, got.read_data);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    raster_scoreboard sb;
    int  burst_left = 0;
    bit  long_stall_req = 1'b0;
    int  n_items = 0, n_chars = 0, n_reads = 0;

    always #5 aclk = ~aclk;

    scaled_font_text_rasterizer DUT (.*);

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_result(resp_t'(m_tdata[17:0]));

    // receiver: random stall pattern, free-running stretches, one long hold-off
    initial begin
        int hold, mode_left, ready_pct;
        hold = 0;
        mode_left = 0;
        ready_pct = 100;
        forever begin
            @(posedge aclk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                hold = 3000;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 20;
                    default: ready_pct = 60;
                endcase
            end
            mode_left--;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    task automatic send_cmd(cmd_t cmd);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= 32'(cmd);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_cmd(cmd);
        n_items++;
        if (cmd.op == OP_CHAR) n_chars++;
        if (cmd.op == OP_READ) n_reads++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // leaves cfg_we high; the caller drops it after its last write
    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    function automatic cmd_t mk(op_t op, int x, int y, int col, int code);
        cmd_t c;
        c.op = op;
        c.pen_x = 7'(x);
        c.pen_y = 6'(y);
        c.color = 2'(col);
        c.char_code = 8'(code);
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int pick;
        c = cmd_t'(25'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 35) c.op = OP_SET;
        else if (pick < 65) c.op = OP_CHAR;
        else if (pick < 98) c.op = OP_READ;
        else c.op = OP_CLEAR;
        // keep most text on printable codes
        if (c.op == OP_CHAR && $urandom_range(0, 3) != 0)
            c.char_code = 8'($urandom_range(32, 126));
        return c;
    endfunction

    initial begin
        int phase_scale [10] = '{1, 2, 8, 3, 0, 12, 15, 1, 4, 9};
        int phase_bg [10]    = '{0, 1, 2, 0, 1, 0, 2, 2, 1, 0};
        int phase_swap [10]  = '{0, 0, 1, 1, 0, 0, 0, 1, 1, 0};
        sb = new();
        sb.init();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corners, every color, glyph code edges, clipping, clear
        send_cmd(mk(OP_SET, 0, 0, COL_WHITE, 0));
        send_cmd(mk(OP_SET, 127, 63, COL_WHITE, 0));
        send_cmd(mk(OP_SET, 127, 63, COL_INVERT, 0));
        send_cmd(mk(OP_SET, 0, 0, COL_KEEP, 0));
        send_cmd(mk(OP_READ, 0, 0, 0, 0));
        send_cmd(mk(OP_READ, 127, 63, 0, 0));
        send_cmd(mk(OP_SET, 0, 0, COL_BLACK, 0));
        send_cmd(mk(OP_CHAR, 0, 0, COL_WHITE, 8'h00));
        send_cmd(mk(OP_CHAR, 6, 0, COL_WHITE, 8'h20));
        send_cmd(mk(OP_CHAR, 12, 0, COL_WHITE, 8'h7E));
        send_cmd(mk(OP_CHAR, 18, 0, COL_INVERT, 8'h7F));
        send_cmd(mk(OP_CHAR, 24, 0, COL_KEEP, 8'hFF));
        send_cmd(mk(OP_CHAR, 125, 3, COL_WHITE, 8'h41));
        send_cmd(mk(OP_CHAR, 122, 60, COL_WHITE, 8'h30));
        send_cmd(mk(OP_READ, 0, 0, 0, 0));
        send_cmd(mk(OP_READ, 14, 7, 0, 0));
        send_cmd(mk(OP_READ, 127, 56, 0, 0));
        send_cmd(mk(OP_CLEAR, 0, 0, 0, 0));
        send_cmd(mk(OP_READ, 14, 0, 0, 0));
        drain();

        for (int p = 0; p < 10; p++) begin
            write_reg(REG_SCALE, 4'(phase_scale[p]));
            write_reg(REG_BG, 4'(phase_bg[p]));
            write_reg(REG_SWAP, 4'(phase_swap[p]));
            cfg_we <= 1'b0;
            @(posedge aclk);
            for (int i = 0; i < 128; i++) begin
                if (p == 0 && i == 10) long_stall_req = 1'b1;
                send_cmd(random_cmd());
            end
            drain();
        end

        $display("Covered %0d items (%0d text, %0d reads), %0d results over 10 register settings.",
                 n_items, n_chars, n_reads, sb.results);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for the block");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
